// ----- hdl/hbsd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hbsd_pkg
// Shared constants for the bit-serial Huffman decoder: default store sizes
// and the fixed widths of the stream fields.
// ============================================================================
package hbsd_pkg;

    // Default size of the node store (leaves and internal nodes together)
    localparam int DEF_MAX_NODES   = 511;
    // Default depth of the open-node stack used while the tree is read in
    localparam int DEF_STACK_DEPTH = 256;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

endpackage

// ----- hdl/huffman_bit_serial_decoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// huffman_bit_serial_decoder
// Bit-serial Huffman decoder: reads a preorder code tree, then decodes code
// bits into bytes until byte_count bytes are out.
// ============================================================================
// The decoder takes one compressed bit per clock cycle while in_stall is low,
// with no gaps, in every phase: tree tags, leaf bytes and code bits alike.
// A decoded byte is registered in the output register, or in the skid entry
// if the output stalls; the two-entry buffer lets the input keep moving while
// one result waits; in_stall rises only when both are held. The rate is set
// by the node store read: each internal node keeps both child descriptors
// (leaf byte or node index), and the record of the current walk node sits in
// the read register of the node store, so one bit needs one table lookup.
// The node store and stack are not cleared by reset or start_of_stream; the
// tree writes every entry before it is read, so no clearing is needed. The user
// must write byte_count only while the decoder is idle; this is not enforced.
module huffman_bit_serial_decoder #(
    parameter int MAX_NODES   = hbsd_pkg::DEF_MAX_NODES,
    parameter int STACK_DEPTH = hbsd_pkg::DEF_STACK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [hbsd_pkg::COUNT_W-1:0] cfg_wr_data,
    // bit stream input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         code_bit,
    input  logic                         start_of_stream,
    // decoded bytes
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [hbsd_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_byte,
    output logic                         tree_error
);

    localparam int BW    = hbsd_pkg::BYTE_W;
    localparam int CW    = hbsd_pkg::COUNT_W;
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SD_W  = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W = (IDX_W > BW) ? IDX_W : BW;

    // child descriptor: leaf byte or index of an internal node
    typedef struct packed {
        logic             leaf;
        logic [VAL_W-1:0] val;
    } desc_t;

    // internal node record
    typedef struct packed {
        desc_t left;
        desc_t right;
    } rec_t;

    // open-node stack entry
    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             left_done;
        desc_t            left;
    } entry_t;

    typedef enum logic [1:0] {
        PH_TREE,
        PH_LEAF,
        PH_DECODE,
        PH_HALT
    } phase_t;

    // result request
    typedef struct packed {
        logic [BW-1:0] data;
        logic          last;
        logic          err;
    } res_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [CW-1:0]    byte_count_reg;
    phase_t           phase_reg,     phase_next;
    logic [NC_W-1:0]  nodes_reg,     nodes_next;
    logic [SD_W-1:0]  depth_reg,     depth_next;
    entry_t           top_reg,       top_next;
    entry_t           below_reg;
    logic [2:0]       leaf_cnt_reg,  leaf_cnt_next;
    logic [BW-1:0]    shift_reg,     shift_next;
    logic [IDX_W-1:0] walk_reg,      walk_next;
    logic [CW-1:0]    bytes_reg,     bytes_next;
    rec_t             rec_reg;

    logic             out_valid_reg;
    res_t             out_reg;
    logic             skid_valid_reg;
    res_t             skid_reg;

    // memories
    rec_t             node_mem [MAX_NODES];
    entry_t           stk_mem  [STACK_DEPTH];

    // ------------------------------------------------------------------------
    // Combinational step
    // ------------------------------------------------------------------------
    logic             accept;
    logic             res_valid;
    res_t             res;
    logic             stk_wr_en;
    logic [SA_W-1:0]  stk_wr_addr;
    entry_t           stk_wr_data;
    logic [SA_W-1:0]  stk_rd_addr;
    logic             node_wr_en;
    logic [IDX_W-1:0] node_wr_addr;
    rec_t             node_wr_data;
    desc_t            new_desc;
    desc_t            side;
    entry_t           new_entry;
    logic [IDX_W-1:0] new_idx;
    logic [CW-1:0]    emit_count;

    assign accept     = in_valid && !in_stall;
    assign emit_count = bytes_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        nodes_next    = nodes_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        leaf_cnt_next = leaf_cnt_reg;
        shift_next    = shift_reg;
        walk_next     = walk_reg;
        bytes_next    = bytes_reg;
        stk_wr_en     = 1'b0;
        stk_wr_addr   = '0;
        stk_wr_data   = top_reg;
        node_wr_en    = 1'b0;
        node_wr_addr  = '0;
        node_wr_data  = '0;
        res_valid     = 1'b0;
        res           = '0;
        new_idx       = nodes_reg[IDX_W-1:0];
        new_desc      = '0;
        new_entry     = '0;
        side          = '0;

        if (accept)
        begin
            // a start flag clears the stream state, then the bit is a tree tag
            if (start_of_stream)
            begin
                phase_next    = PH_TREE;
                nodes_next    = '0;
                depth_next    = '0;
                leaf_cnt_next = '0;
                shift_next    = '0;
                walk_next     = '0;
                bytes_next    = '0;
            end

            unique case (phase_next)
                PH_TREE:
                begin
                    if (nodes_next >= NC_W'(MAX_NODES) ||
                        (!code_bit && depth_next >= SD_W'(STACK_DEPTH)))
                    begin
                        // node store or stack overflow
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res.err    = 1'b1;
                    end
                    else
                    begin
                        new_idx    = nodes_next[IDX_W-1:0];
                        nodes_next = nodes_next + 1'b1;
                        if (!code_bit)
                        begin
                            // internal node: link to parent, then open it
                            new_desc.leaf   = 1'b0;
                            new_desc.val    = VAL_W'(new_idx);
                            new_entry.node  = new_idx;
                            if (depth_next == '0)
                            begin
                                depth_next = SD_W'(1);
                            end
                            else if (!top_reg.left_done)
                            begin
                                stk_wr_en             = 1'b1;
                                stk_wr_addr           = SA_W'(depth_next - 1'b1);
                                stk_wr_data           = top_reg;
                                stk_wr_data.left_done = 1'b1;
                                stk_wr_data.left      = new_desc;
                                depth_next            = depth_next + 1'b1;
                            end
                            else
                            begin
                                // right child closes the parent: pop and push
                                node_wr_en         = 1'b1;
                                node_wr_addr       = top_reg.node;
                                node_wr_data.left  = top_reg.left;
                                node_wr_data.right = new_desc;
                            end
                            top_next = new_entry;
                        end
                        else
                        begin
                            // leaf: its byte follows, linked once complete
                            phase_next    = PH_LEAF;
                            leaf_cnt_next = '0;
                            shift_next    = '0;
                        end
                    end
                end

                PH_LEAF:
                begin
                    shift_next = {shift_reg[BW-2:0], code_bit};
                    if (leaf_cnt_reg != 3'd7)
                    begin
                        leaf_cnt_next = leaf_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        leaf_cnt_next = '0;
                        new_desc.leaf = 1'b1;
                        new_desc.val  = VAL_W'(shift_next);
                        if (depth_reg != '0)
                        begin
                            if (!top_reg.left_done)
                            begin
                                top_next.left_done = 1'b1;
                                top_next.left      = new_desc;
                            end
                            else
                            begin
                                node_wr_en         = 1'b1;
                                node_wr_addr       = top_reg.node;
                                node_wr_data.left  = top_reg.left;
                                node_wr_data.right = new_desc;
                                depth_next         = depth_reg - 1'b1;
                                top_next           = below_reg;
                            end
                        end
                        phase_next = (depth_next == '0) ? PH_DECODE : PH_TREE;
                        walk_next  = '0;
                    end
                end

                PH_DECODE:
                begin
                    if (bytes_reg < byte_count_reg)
                    begin
                        if (nodes_reg == NC_W'(1))
                        begin
                            // single-leaf tree: every bit gives the root byte
                            side.leaf = 1'b1;
                            side.val  = VAL_W'(shift_reg);
                        end
                        else
                        begin
                            side = code_bit ? rec_reg.right : rec_reg.left;
                        end
                        if (side.leaf)
                        begin
                            walk_next  = '0;
                            bytes_next = emit_count;
                            res_valid  = 1'b1;
                            res.data   = side.val[BW-1:0];
                            res.last   = (emit_count == byte_count_reg);
                        end
                        else
                        begin
                            walk_next = side.val[IDX_W-1:0];
                        end
                    end
                end

                PH_HALT:
                begin
                    // ignore bits until the next start flag
                end

                default:
                begin
                end
            endcase
        end
    end

    // entry below the top of stack, read for the next cycle
    assign stk_rd_addr = (depth_next >= SD_W'(2)) ? SA_W'(depth_next - SD_W'(2)) : '0;

    // ------------------------------------------------------------------------
    // Memories: node store and open-node stack
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (node_wr_en)
        begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        // record of the next walk node, with write bypass
        if (node_wr_en && node_wr_addr == walk_next)
        begin
            rec_reg <= node_wr_data;
        end
        else
        begin
            rec_reg <= node_mem[walk_next];
        end

        if (stk_wr_en)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
            below_reg            <= stk_wr_data;
        end
        else
        begin
            below_reg <= stk_mem[stk_rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Control state and output buffer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            phase_reg      <= PH_TREE;
            nodes_reg      <= '0;
            depth_reg      <= '0;
            top_reg        <= '0;
            leaf_cnt_reg   <= '0;
            shift_reg      <= '0;
            walk_reg       <= '0;
            bytes_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            skid_valid_reg <= 1'b0;
            skid_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                byte_count_reg <= cfg_wr_data;
            end
            phase_reg    <= phase_next;
            nodes_reg    <= nodes_next;
            depth_reg    <= depth_next;
            top_reg      <= top_next;
            leaf_cnt_reg <= leaf_cnt_next;
            shift_reg    <= shift_next;
            walk_reg     <= walk_next;
            bytes_reg    <= bytes_next;

            // two-entry output buffer
            if (skid_valid_reg)
            begin
                if (!out_stall)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= res_valid;
                out_reg       <= res;
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= res;
            end
        end
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_reg.data;
    assign last_byte  = out_reg.last;
    assign tree_error = out_reg.err;

endmodule

// ----- sim/huffman_bit_serial_decoder_check.sv -----
`timescale 1ns / 1ps
// ============================================================================
// huffman_bit_serial_decoder_check
// Watches both channels and the byte_count port of the decoder, keeps its
// own copy of the tree store and walk state, and compares every decoded
// byte with the oldest predicted one. Failures and the number of bytes still
// owed are handed to the test top.
// ============================================================================
module huffman_bit_serial_decoder_check #(
    parameter int MAX_NODES   = hbsd_pkg::DEF_MAX_NODES,
    parameter int STACK_DEPTH = hbsd_pkg::DEF_STACK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [hbsd_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         code_bit,
    input  logic                         start_of_stream,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [hbsd_pkg::BYTE_W-1:0]  out_byte,
    input  logic                         last_byte,
    input  logic                         tree_error,
    output int                           fail_count,
    output int                           pending
);

    typedef enum logic [1:0] {TAG_BITS, LEAF_BITS, CODE_WALK, HALTED} walk_phase_t;

    typedef struct packed {
        logic [hbsd_pkg::BYTE_W-1:0] value;
        logic                        last;
        logic                        err;
    } decoded_t;

    // Byte count register as the decoder holds it
    logic [hbsd_pkg::COUNT_W-1:0] count_limit;

    // Tree store: a leaf keeps its byte in node_left
    bit          node_is_leaf [MAX_NODES];
    int unsigned node_left    [MAX_NODES];
    int unsigned node_right   [MAX_NODES];

    // Nodes still waiting for a child
    int unsigned open_node     [STACK_DEPTH];
    bit          open_left_set [STACK_DEPTH];

    int unsigned                  open_depth;
    int unsigned                  node_fill;
    int unsigned                  leaf_bits;
    int unsigned                  walk_at;
    logic [7:0]                   leaf_acc;
    logic [hbsd_pkg::COUNT_W-1:0] bytes_out;
    walk_phase_t                  walk_phase;

    decoded_t byte_queue [$];

    // Forget the current tree and start reading a new one
    function automatic void restart_stream();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            node_is_leaf[i] = 1'b0;
            node_left[i]    = 0;
            node_right[i]   = 0;
        end
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            open_node[i]     = 0;
            open_left_set[i] = 1'b0;
        end
        open_depth = 0;
        node_fill  = 0;
        walk_phase = TAG_BITS;
        leaf_bits  = 0;
        leaf_acc   = '0;
        walk_at    = 0;
        bytes_out  = '0;
    endfunction

    // Hook a new node under the innermost open parent, left side first
    function automatic void hang_on_parent(input int unsigned n);
        int unsigned p;
        if (open_depth == 0 || open_depth > STACK_DEPTH)
            return;
        p = open_node[open_depth - 1];
        if (p >= MAX_NODES)
            return;
        if (!open_left_set[open_depth - 1])
        begin
            node_left[p]                  = n;
            open_left_set[open_depth - 1] = 1'b1;
        end
        else
        begin
            node_right[p] = n;
            open_depth--;
        end
    endfunction

    function automatic void halt_stream(output decoded_t res);
        walk_phase = HALTED;
        res        = '0;
        res.err    = 1'b1;
    endfunction

    // One bit request; returns 1 when it yields a byte or an error
    function automatic bit decode_bit(input logic b, input logic sos, output decoded_t res);
        int unsigned n;
        res = '0;
        if (sos)
            restart_stream();
        case (walk_phase)
            TAG_BITS:
            begin
                if (node_fill >= MAX_NODES)
                begin
                    halt_stream(res);
                    return 1'b1;
                end
                n = node_fill;
                if (!b)
                begin
                    if (open_depth >= STACK_DEPTH)
                    begin
                        halt_stream(res);
                        return 1'b1;
                    end
                    node_fill++;
                    node_is_leaf[n] = 1'b0;
                    node_left[n]    = 0;
                    node_right[n]   = 0;
                    hang_on_parent(n);
                    open_node[open_depth]     = n;
                    open_left_set[open_depth] = 1'b0;
                    open_depth++;
                end
                else
                begin
                    node_fill++;
                    node_is_leaf[n] = 1'b1;
                    node_left[n]    = 0;
                    node_right[n]   = 0;
                    hang_on_parent(n);
                    leaf_bits  = 0;
                    leaf_acc   = '0;
                    walk_phase = LEAF_BITS;
                end
                return 1'b0;
            end
            LEAF_BITS:
            begin
                leaf_acc = {leaf_acc[6:0], b};
                if (leaf_bits < 7)
                begin
                    leaf_bits++;
                    return 1'b0;
                end
                leaf_bits = 0;
                n = node_fill - 1;
                if (n < MAX_NODES)
                    node_left[n] = 32'(leaf_acc);
                walk_phase = (open_depth == 0) ? CODE_WALK : TAG_BITS;
                walk_at    = 0;
                return 1'b0;
            end
            CODE_WALK:
            begin
                if (bytes_out >= count_limit)
                    return 1'b0;
                n = walk_at;
                if (n >= MAX_NODES)
                    n = 0;
                // a single-leaf tree emits the root byte on every bit
                if (!node_is_leaf[n])
                begin
                    n = b ? node_right[n] : node_left[n];
                    if (n >= MAX_NODES)
                        n = 0;
                    if (!node_is_leaf[n])
                    begin
                        walk_at = n;
                        return 1'b0;
                    end
                end
                walk_at = 0;
                bytes_out++;
                res.value = 8'(node_left[n]);
                res.last  = (bytes_out == count_limit);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void note_miss(input string what, input decoded_t want,
                                      input decoded_t got);
        if (fail_count < 10)
            $display("%0t ns: %s: expected byte %02h last %b err %b, got byte %02h last %b err %b",
                     $time, what, want.value, want.last, want.err,
                     got.value, got.last, got.err);
        fail_count++;
    endfunction

    // Predict on each accepted request, compare on each accepted byte
    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_t want;
        decoded_t got;
        if (!rst_n)
        begin
            count_limit = '0;
            restart_stream();
            byte_queue.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                count_limit = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (decode_bit(code_bit, start_of_stream, want))
                    byte_queue.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got.value = out_byte;
                got.last  = last_byte;
                got.err   = tree_error;
                if (byte_queue.size() == 0)
                    note_miss("unexpected byte", '0, got);
                else
                begin
                    want = byte_queue.pop_front();
                    if (got !== want)
                        note_miss("byte mismatch", want, got);
                end
            end
            pending = byte_queue.size();
        end
    end

endmodule

// ----- sim/huffman_bit_serial_decoder_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// huffman_bit_serial_decoder_test
// Drives bit streams into the Huffman decoder: a directed set covering
// leaf byte extremes, a zero and a changed byte count, a stream with no start
// flag, stack and node store overflow, then random trees with random codes
// mixed with noise streams. Checking is done by the check module.
// ============================================================================
module huffman_bit_serial_decoder_test;

    logic                         clk             = 1'b0;
    logic                         rst_n           = 1'b0;
    logic                         cfg_wr_en       = 1'b0;
    logic [hbsd_pkg::COUNT_W-1:0] cfg_wr_data     = '0;
    logic                         in_valid        = 1'b0;
    logic                         code_bit        = 1'b0;
    logic                         start_of_stream = 1'b0;
    logic                         out_stall       = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [hbsd_pkg::BYTE_W-1:0]  out_byte;
    logic                         last_byte;
    logic                         tree_error;

    int fail_count;
    int pending;
    int sent;
    bit in_gaps  = 1'b1;
    bit out_gaps = 1'b1;

    always #1 clk = ~clk;

    huffman_bit_serial_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .code_bit        (code_bit),
        .start_of_stream (start_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_byte       (last_byte),
        .tree_error      (tree_error)
    );

    huffman_bit_serial_decoder_check decode_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .code_bit        (code_bit),
        .start_of_stream (start_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_byte       (last_byte),
        .tree_error      (tree_error),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= out_gaps && ($urandom_range(99) < 17);

    // One bit request, held until accepted
    task automatic push_bit(input logic b, input logic sos);
        while (in_gaps && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        code_bit        <= b;
        start_of_stream <= sos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Leaf tag followed by its byte, MSB first
    task automatic push_leaf(input logic [7:0] v, input logic sos);
        push_bit(1'b1, sos);
        for (int i = 7; i >= 0; i--)
            push_bit(v[i], 1'b0);
    endtask

    task automatic push_codes(input int n);
        repeat (n)
            push_bit(1'($urandom_range(1)), 1'b0);
    endtask

    // Random full tree in preorder with the given number of leaves
    task automatic push_tree(input int leaves);
        int   inner_left;
        int   leaf_left;
        int   open_slots;
        bit   leaf_ok;
        logic sos;
        logic [7:0] v;
        inner_left = leaves - 1;
        leaf_left  = leaves;
        open_slots = 1;
        sos        = 1'b1;
        while (open_slots > 0)
        begin
            // a leaf may close the tree only when no internal node is left
            leaf_ok = (leaf_left > 0) && (open_slots > 1 || inner_left == 0);
            if (inner_left > 0 && (!leaf_ok || $urandom_range(1)))
            begin
                push_bit(1'b0, sos);
                inner_left--;
                open_slots++;
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    v = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    v = 8'($urandom_range(255));
                push_leaf(v, sos);
                leaf_left--;
                open_slots--;
            end
            sos = 1'b0;
        end
    endtask

    // Sender pauses until every byte owed has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic set_count(input logic [hbsd_pkg::COUNT_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int stream_no;
        int len;
        logic [hbsd_pkg::COUNT_W-1:0] limit;
        sent = 0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no start flag after reset; count still zero, so nothing comes out
        push_leaf(8'hA5, 1'b0);
        push_codes(3);
        // raising the count resumes the single-leaf tree at once
        set_count(3);
        push_codes(4);

        // two-leaf tree with extreme leaf bytes
        set_count(32'hFFFF_FFFF);
        push_bit(1'b0, 1'b1);
        push_leaf(8'h00, 1'b0);
        push_leaf(8'hFF, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);

        // open-node stack overflow, then bits ignored while halted
        for (int i = 0; i <= hbsd_pkg::DEF_STACK_DEPTH; i++)
            push_bit(1'b0, i == 0);
        push_codes(5);

        // node store overflow: a right-leaning chain keeps the stack shallow
        for (int i = 0; i < (hbsd_pkg::DEF_MAX_NODES - 1) / 2; i++)
        begin
            push_bit(1'b0, i == 0);
            push_leaf(i[7:0], 1'b0);
        end
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_codes(3);

        // random streams
        sent      = 0;
        stream_no = 0;
        while (sent < 600)
        begin
            case ($urandom_range(5))
                0:       limit = 1;
                1:       limit = 32'hFFFF_FFFF;
                2:       limit = $urandom();
                default: limit = $urandom_range(2, 20);
            endcase
            set_count(limit);
            // one stream runs with no idling on either side
            in_gaps  = (stream_no != 2);
            out_gaps = in_gaps;
            if ($urandom_range(99) < 80)
            begin
                push_tree(($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 8));
                push_codes($urandom_range(8, 60));
            end
            else
            begin
                // noise, with an occasional restart in the middle
                len = $urandom_range(20, 80);
                push_bit(1'($urandom_range(1)), 1'b1);
                repeat (len)
                    push_bit(1'($urandom_range(1)), $urandom_range(39) == 0);
            end
            stream_no++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hbsd_pkg.sv
hdl/huffman_bit_serial_decoder.sv
sim/huffman_bit_serial_decoder_check.sv
sim/huffman_bit_serial_decoder_test.sv
